@@ hdl/sha0md_pkg.sv @@
package sha0md_pkg;

    // One input request: a message byte, its presence flag and the end flag.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       final_item;
    } sha0md_in_t;

    // One result request: a digest word with its number and the closing flag.
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_number;
        logic        last_word;
    } sha0md_out_t;

    // Five working or chaining words, index 0 holds a (h0).
    typedef logic [4:0][31:0] sha0md_words_t;

    // Controls of the schedule window.
    typedef struct packed {
        logic push;
        logic step;
        logic first16;
    } sha0md_sched_ctl_t;

    // Controls of the round unit.
    typedef struct packed {
        logic       load;
        logic       step;
        logic [6:0] rnd;
    } sha0md_round_ctl_t;

    localparam logic [6:0] ROUNDS = 7'd80;
    localparam logic [6:0] ROUND_F2 = 7'd20;
    localparam logic [6:0] ROUND_F3 = 7'd40;
    localparam logic [6:0] ROUND_F4 = 7'd60;
    localparam logic [6:0] SCHED_DIRECT = 7'd16;

    localparam logic [31:0] K0 = 32'h5a827999;
    localparam logic [31:0] K1 = 32'h6ed9eba1;
    localparam logic [31:0] K2 = 32'h8f1bbcdc;
    localparam logic [31:0] K3 = 32'hca62c1d6;

    localparam sha0md_words_t INIT_WORDS = {
        32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
    };

    localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
    localparam logic [5:0] POS_BLOCK_LAST = 6'd63;
    localparam logic [5:0] POS_LENGTH = 6'd56;
    localparam logic [2:0] LEN_BYTE_LAST = 3'd7;
    localparam logic [2:0] LAST_WORD_NUM = 3'd4;

endpackage

@@ hdl/sha0md_sched.sv @@
module sha0md_sched (
    input  logic                           clk,
    input  sha0md_pkg::sha0md_sched_ctl_t  ctl,
    input  logic [31:0]                    push_word,
    output logic [31:0]                    wt
);

    // Oldest word at index 0; a new word always enters at index 15.
    logic [15:0][31:0] win_reg;
    logic [31:0]       win_next_word;

    assign wt = ctl.first16 ? win_reg[0]
                            : (win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0]);

    // During the first sixteen rounds the window rotates, so that it again
    // holds w[t-16] .. w[t-1] in order when expansion starts.
    assign win_next_word = ctl.push ? push_word : wt;

    always_ff @(posedge clk)
    begin
        if (ctl.push || ctl.step)
        begin
            win_reg <= {win_next_word, win_reg[15:1]};
        end
    end

endmodule

@@ hdl/sha0md_round.sv @@
module sha0md_round (
    input  logic                           clk,
    input  logic                           rst_n,
    input  sha0md_pkg::sha0md_round_ctl_t  ctl,
    input  sha0md_pkg::sha0md_words_t      chain_words,
    input  logic [31:0]                    wt,
    output sha0md_pkg::sha0md_words_t      round_words
);

    sha0md_pkg::sha0md_words_t round_words_reg;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
    logic [31:0] f;
    logic [31:0] k;
    logic [31:0] tmp;

    assign a = round_words_reg[0];
    assign b = round_words_reg[1];
    assign c = round_words_reg[2];
    assign d = round_words_reg[3];
    assign e = round_words_reg[4];

    always_comb
    begin
        if (ctl.rnd < sha0md_pkg::ROUND_F2)
        begin
            f = (b & c) | (~b & d);
            k = sha0md_pkg::K0;
        end
        else if (ctl.rnd < sha0md_pkg::ROUND_F3)
        begin
            f = b ^ c ^ d;
            k = sha0md_pkg::K1;
        end
        else if (ctl.rnd < sha0md_pkg::ROUND_F4)
        begin
            f = (b & c) | (b & d) | (c & d);
            k = sha0md_pkg::K2;
        end
        else
        begin
            f = b ^ c ^ d;
            k = sha0md_pkg::K3;
        end
        tmp = {a[26:0], a[31:27]} + f + e + k + wt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            round_words_reg <= '0;
        end
        else if (ctl.load)
        begin
            round_words_reg <= chain_words;
        end
        else if (ctl.step)
        begin
            round_words_reg <= {d, c, {b[1:0], b[31:2]}, a, tmp};
        end
    end

    assign round_words = round_words_reg;

endmodule

@@ hdl/sha0_message_digest_top.sv @@
// SHA-0 digest engine. Send the message one byte per request on the input
// channel, with final_item set on the last request; a request that has
// final_item set and byte_present clear ends the message without adding a
// byte, so it also encodes an empty message. Requests with neither flag set
// are ignored. After the final request the block pads the message, finishes
// compression and delivers the five digest words h0 through h4 as five
// result requests, last_word marking h4; it then starts over for the next
// message. The input is taken in one cycle per byte while a block is being
// filled; the byte that completes a 64-byte block starts its compression,
// 80 rounds through the single round unit, one round per cycle, followed
// by an add into the chaining words. The final request adds the padding,
// which is fed one byte per cycle through the same byte path, with a step
// before the length field that places no byte, and each padded block is
// compressed in the same way before the digest words appear. The input is
// not ready while rounds, padding or digest output are in progress.
// LENGTH_COUNT_BITS sets the width of the byte counter; the encoded bit
// length wraps modulo 2 to that power times eight.
module sha0_message_digest_top #(
    parameter int LENGTH_COUNT_BITS = 61
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  sha0md_pkg::sha0md_in_t   in_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output sha0md_pkg::sha0md_out_t  out_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_PAD_MARK,
        ST_PAD_ZERO,
        ST_PAD_LEN,
        ST_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    sha0md_pkg::sha0md_words_t chain_reg;
    sha0md_pkg::sha0md_words_t round_words;

    logic [LENGTH_COUNT_BITS-1:0] count_reg;
    logic [5:0]  pos_reg;
    logic [23:0] word_acc_reg;
    logic [6:0]  rnd_reg;
    logic [2:0]  len_idx_reg;
    logic [2:0]  out_idx_reg;
    logic        final_seen_reg;
    logic        mark_done_reg;
    logic        len_done_reg;

    logic        in_take;
    logic        place;
    logic [7:0]  place_byte;
    logic        start_comp;
    logic [63:0] len_bits;
    logic [7:0]  len_byte;
    logic [31:0] wt;

    sha0md_pkg::sha0md_sched_ctl_t sched_ctl;
    sha0md_pkg::sha0md_round_ctl_t round_ctl;

    // The length field is the byte count times eight, big-endian over 64 bits.
    assign len_bits = 64'({count_reg, 3'b000});
    assign len_byte = len_bits[{~len_idx_reg, 3'b000} +: 8];

    assign in_ready = (state_reg == ST_IDLE);
    assign in_take  = in_valid && in_ready;

    // Message bytes and padding bytes share one path into the window. The
    // block position counts both, while the message count only sees real
    // message bytes.
    always_comb
    begin
        state_next = state_reg;
        place      = 1'b0;
        place_byte = '0;
        start_comp = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    if (in_data.byte_present)
                    begin
                        place      = 1'b1;
                        place_byte = in_data.data_byte;
                        if (pos_reg == sha0md_pkg::POS_BLOCK_LAST)
                        begin
                            start_comp = 1'b1;
                            state_next = ST_ROUND;
                        end
                        else if (in_data.final_item)
                        begin
                            state_next = ST_PAD_MARK;
                        end
                    end
                    else if (in_data.final_item)
                    begin
                        state_next = ST_PAD_MARK;
                    end
                end
            end
            ST_ROUND:
            begin
                if (rnd_reg == sha0md_pkg::ROUNDS - 7'd1)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                if (len_done_reg)
                begin
                    state_next = ST_OUT;
                end
                else if (final_seen_reg)
                begin
                    state_next = mark_done_reg ? ST_PAD_ZERO : ST_PAD_MARK;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PAD_MARK:
            begin
                place      = 1'b1;
                place_byte = sha0md_pkg::PAD_MARK_BYTE;
                if (pos_reg == sha0md_pkg::POS_BLOCK_LAST)
                begin
                    start_comp = 1'b1;
                    state_next = ST_ROUND;
                end
                else
                begin
                    state_next = ST_PAD_ZERO;
                end
            end
            ST_PAD_ZERO:
            begin
                if (pos_reg == sha0md_pkg::POS_LENGTH)
                begin
                    state_next = ST_PAD_LEN;
                end
                else
                begin
                    place = 1'b1;
                    if (pos_reg == sha0md_pkg::POS_BLOCK_LAST)
                    begin
                        start_comp = 1'b1;
                        state_next = ST_ROUND;
                    end
                end
            end
            ST_PAD_LEN:
            begin
                place      = 1'b1;
                place_byte = len_byte;
                if (len_idx_reg == sha0md_pkg::LEN_BYTE_LAST)
                begin
                    start_comp = 1'b1;
                    state_next = ST_ROUND;
                end
            end
            ST_OUT:
            begin
                if (out_ready && (out_idx_reg == sha0md_pkg::LAST_WORD_NUM))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            chain_reg      <= sha0md_pkg::INIT_WORDS;
            count_reg      <= '0;
            pos_reg        <= '0;
            rnd_reg        <= '0;
            len_idx_reg    <= '0;
            out_idx_reg    <= '0;
            final_seen_reg <= 1'b0;
            mark_done_reg  <= 1'b0;
            len_done_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (place)
            begin
                pos_reg <= pos_reg + 6'd1;
            end

            if (in_take)
            begin
                if (in_data.byte_present)
                begin
                    count_reg <= count_reg + LENGTH_COUNT_BITS'(1);
                end
                if (in_data.final_item)
                begin
                    final_seen_reg <= 1'b1;
                end
            end

            if (start_comp)
            begin
                rnd_reg <= '0;
            end
            else if (state_reg == ST_ROUND)
            begin
                rnd_reg <= rnd_reg + 7'd1;
            end

            if (state_reg == ST_FOLD)
            begin
                for (int i = 0; i < 5; i++)
                begin
                    chain_reg[i] <= chain_reg[i] + round_words[i];
                end
            end

            if (state_reg == ST_PAD_MARK)
            begin
                mark_done_reg <= 1'b1;
            end

            if (state_reg == ST_PAD_LEN)
            begin
                len_idx_reg <= len_idx_reg + 3'd1;
                if (len_idx_reg == sha0md_pkg::LEN_BYTE_LAST)
                begin
                    len_done_reg <= 1'b1;
                end
            end

            // After h4 is taken, everything returns to the start of a message.
            if ((state_reg == ST_OUT) && out_ready)
            begin
                if (out_idx_reg == sha0md_pkg::LAST_WORD_NUM)
                begin
                    out_idx_reg    <= '0;
                    chain_reg      <= sha0md_pkg::INIT_WORDS;
                    count_reg      <= '0;
                    pos_reg        <= '0;
                    final_seen_reg <= 1'b0;
                    mark_done_reg  <= 1'b0;
                    len_done_reg   <= 1'b0;
                end
                else
                begin
                    out_idx_reg <= out_idx_reg + 3'd1;
                end
            end
        end
    end

    // Bytes gather big-endian into a word; the fourth byte pushes the word.
    always_ff @(posedge clk)
    begin
        if (place && (pos_reg[1:0] != 2'd3))
        begin
            word_acc_reg <= {word_acc_reg[15:0], place_byte};
        end
    end

    assign sched_ctl.push    = place && (pos_reg[1:0] == 2'd3);
    assign sched_ctl.step    = (state_reg == ST_ROUND);
    assign sched_ctl.first16 = (rnd_reg < sha0md_pkg::SCHED_DIRECT);

    assign round_ctl.load = start_comp;
    assign round_ctl.step = (state_reg == ST_ROUND);
    assign round_ctl.rnd  = rnd_reg;

    sha0md_sched u_sched (
        .clk       (clk),
        .ctl       (sched_ctl),
        .push_word ({word_acc_reg, place_byte}),
        .wt        (wt)
    );

    sha0md_round u_round (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (round_ctl),
        .chain_words (chain_reg),
        .wt          (wt),
        .round_words (round_words)
    );

    assign out_valid            = (state_reg == ST_OUT);
    assign out_data.digest_word = chain_reg[out_idx_reg];
    assign out_data.word_number = out_idx_reg;
    assign out_data.last_word   = (out_idx_reg == sha0md_pkg::LAST_WORD_NUM);

endmodule
